/* rtl/key_value_table_store_top_defines.svh */
// ----------------------------------------------------------------------------
// Key/value table store - assertion macros
// Concurrent assertion wrappers; NO_ASSERTIONS removes them.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_STORE_TOP_DEFINES_SVH
`define KEY_VALUE_TABLE_STORE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define KVTS_ASSERT(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("kvts assertion failed");
// checked at every edge, reset included
`define KVTS_ASSERT_ALWAYS(label, clk_sig, prop) \
  label: assert property (@(posedge clk_sig) prop) \
    else $error("kvts assertion failed");
`else
`define KVTS_ASSERT(label, clk_sig, rst_sig, prop)
`define KVTS_ASSERT_ALWAYS(label, clk_sig, prop)
`endif

`endif

/* rtl/kvts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table store package
// Field widths, default sizes, codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package kvts_pkg;

  localparam int FIELD_W = 64;
  localparam int LEN_W   = 4;

  localparam int RECORD_COUNT_DEF = 16;
  localparam int KEY_BYTES_DEF    = 8;
  localparam int VALUE_BYTES_DEF  = 8;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ARG   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic    load_req;
    logic    scan;
    logic    write;
    logic    fetch;
    logic    load_rsp;
    status_t rsp_status;
    logic    rsp_data;
  } kvts_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_read;
    logic scan_last;
    logic hit;
    logic free_found;
    logic rsp_free;
  } kvts_stat_t;

  // ones over the low n bytes of a word
  function automatic logic [FIELD_W-1:0] byte_mask(logic [LEN_W-1:0] n);
    logic [FIELD_W-1:0] m;
    m = '0;
    for (int i = 0; i < FIELD_W / 8; i++) begin
      m[8*i +: 8] = (LEN_W'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

/* rtl/kvts_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table store request channel
// valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface kvts_req_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [kvts_pkg::FIELD_W-1:0] key_bytes;
  logic [kvts_pkg::LEN_W-1:0]   key_length;
  logic [kvts_pkg::FIELD_W-1:0] value_bytes;
  logic [kvts_pkg::LEN_W-1:0]   value_length;

  modport source (
    output valid, opcode, key_bytes, key_length, value_bytes, value_length,
    input  ready
  );
  modport sink (
    input  valid, opcode, key_bytes, key_length, value_bytes, value_length,
    output ready
  );
endinterface

/* rtl/kvts_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table store response channel
// valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface kvts_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [kvts_pkg::FIELD_W-1:0] read_value;
  logic [kvts_pkg::LEN_W-1:0]   read_length;

  modport source (
    output valid, status, read_value, read_length,
    input  ready
  );
  modport sink (
    input  valid, status, read_value, read_length,
    output ready
  );
endinterface

/* rtl/kvts_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table store controller
// Sequences accept, key scan, update or fetch, and the result load.
// ----------------------------------------------------------------------------
module kvts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  kvts_pkg::kvts_stat_t st,
  output kvts_pkg::kvts_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FINISH
  } state_t;

  state_t             state;
  state_t             state_next;
  kvts_pkg::status_t  rsp_code;
  kvts_pkg::status_t  rsp_code_next;
  logic               rsp_data;
  logic               rsp_data_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    rsp_code_next   = rsp_code;
    rsp_data_next   = rsp_data;
    cmd             = '0;
    cmd.rsp_status  = rsp_code;
    cmd.rsp_data    = rsp_data;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.bad) begin
          rsp_code_next = kvts_pkg::ST_BAD_ARG;
          rsp_data_next = 1'b0;
          state_next    = S_FINISH;
        end else begin
          cmd.scan = 1'b1;
          if (st.scan_last) begin
            state_next = S_DRAIN;
          end
        end
      end
      // last compare lands this cycle
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next    = S_FINISH;
        rsp_data_next = 1'b0;
        if (st.is_read) begin
          if (st.hit) begin
            cmd.fetch     = 1'b1;
            rsp_code_next = kvts_pkg::ST_OK;
            rsp_data_next = 1'b1;
          end else begin
            rsp_code_next = kvts_pkg::ST_NOT_FOUND;
          end
        end else begin
          if (st.hit || st.free_found) begin
            cmd.write     = 1'b1;
            rsp_code_next = kvts_pkg::ST_OK;
          end else begin
            rsp_code_next = kvts_pkg::ST_FULL;
          end
        end
      end
      S_FINISH: begin
        if (st.rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp_code <= kvts_pkg::ST_OK;
      rsp_data <= 1'b0;
    end else begin
      state    <= state_next;
      rsp_code <= rsp_code_next;
      rsp_data <= rsp_data_next;
    end
  end

endmodule

/* rtl/kvts_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table store datapath
// Argument check, record memories, one-entry-per-cycle key scan, result reg.
// ----------------------------------------------------------------------------
module kvts_datapath #(
  parameter int RECORD_COUNT = kvts_pkg::RECORD_COUNT_DEF,
  parameter int KEY_BYTES    = kvts_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BYTES  = kvts_pkg::VALUE_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         opcode,
  input  logic [kvts_pkg::FIELD_W-1:0] key_bytes,
  input  logic [kvts_pkg::LEN_W-1:0]   key_length,
  input  logic [kvts_pkg::FIELD_W-1:0] value_bytes,
  input  logic [kvts_pkg::LEN_W-1:0]   value_length,
  input  kvts_pkg::kvts_cmd_t          cmd,
  output kvts_pkg::kvts_stat_t         st,
  input  logic                         rsp_ready,
  output logic                         rsp_valid,
  output logic [1:0]                   rsp_status,
  output logic [kvts_pkg::FIELD_W-1:0] rsp_value,
  output logic [kvts_pkg::LEN_W-1:0]   rsp_length
);

  localparam int IDX_W = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int VAL_W = 8 * VALUE_BYTES;
  localparam int LEN_W = kvts_pkg::LEN_W;
  localparam logic [LEN_W-1:0] KEY_MAX = LEN_W'(KEY_BYTES);
  localparam logic [LEN_W-1:0] VAL_MAX = LEN_W'(VALUE_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORD_COUNT - 1);

  // record storage
  logic [KEY_W-1:0] keys_mem [RECORD_COUNT];
  logic [VAL_W-1:0] vals_mem [RECORD_COUNT];
  logic [LEN_W-1:0] lens_mem [RECORD_COUNT];
  logic             occupied [RECORD_COUNT];

  // captured request
  kvts_pkg::opcode_t req_op;
  logic              req_bad;
  logic [KEY_W-1:0]  req_key;
  logic [VAL_W-1:0]  req_val;
  logic [LEN_W-1:0]  req_vlen;

  // scan pipeline
  logic [IDX_W-1:0] scan_addr;
  logic [IDX_W-1:0] cmp_addr;
  logic             cmp_en;
  logic [KEY_W-1:0] key_rd;
  logic             occ_rd;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] wr_idx;

  logic [VAL_W-1:0] fetch_val;
  logic [LEN_W-1:0] fetch_len;

  logic [kvts_pkg::FIELD_W-1:0] key_packed;
  logic [kvts_pkg::FIELD_W-1:0] val_packed;
  logic                         zero_byte;
  logic                         key_bad;
  logic                         val_bad;

  always_comb begin
    zero_byte = 1'b0;
    for (int i = 0; i < kvts_pkg::FIELD_W / 8; i++) begin
      if ((LEN_W'(i) < key_length) && (key_bytes[8*i +: 8] == 8'h00)) begin
        zero_byte = 1'b1;
      end
    end
  end

  assign key_bad    = (key_length == '0) || (key_length > KEY_MAX) || zero_byte;
  assign val_bad    = (opcode == kvts_pkg::OP_WRITE) &&
                      ((value_length == '0) || (value_length > VAL_MAX));
  assign key_packed = key_bytes & kvts_pkg::byte_mask(key_length);
  assign val_packed = value_bytes & kvts_pkg::byte_mask(value_length);
  assign wr_idx     = hit ? hit_idx : free_idx;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op   <= kvts_pkg::opcode_t'(opcode);
      req_bad  <= key_bad || val_bad;
      req_key  <= key_packed[KEY_W-1:0];
      req_val  <= val_packed[VAL_W-1:0];
      req_vlen <= value_length;
    end
  end

  // memories: one write port, one read port each
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      keys_mem[wr_idx] <= req_key;
      vals_mem[wr_idx] <= req_val;
      lens_mem[wr_idx] <= req_vlen;
    end
    if (cmd.scan) begin
      key_rd <= keys_mem[scan_addr];
    end
    if (cmd.fetch) begin
      fetch_val <= vals_mem[hit_idx];
      fetch_len <= lens_mem[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RECORD_COUNT; i++) begin
        occupied[i] <= 1'b0;
      end
    end else if (cmd.write) begin
      occupied[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      occ_rd   <= occupied[scan_addr];
      cmp_addr <= scan_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr  <= '0;
      cmp_en     <= 1'b0;
      hit        <= 1'b0;
      hit_idx    <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
    end else if (cmd.load_req) begin
      scan_addr  <= '0;
      cmp_en     <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
      if (cmd.scan) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (cmp_en) begin
        if (occ_rd && (key_rd == req_key)) begin
          hit     <= 1'b1;
          hit_idx <= cmp_addr;
        end
        // first free slot only
        if (!occ_rd && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_addr;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      rsp_status <= cmd.rsp_status;
      rsp_value  <= cmd.rsp_data ? kvts_pkg::FIELD_W'(fetch_val) : '0;
      rsp_length <= cmd.rsp_data ? fetch_len : '0;
    end
  end

  always_comb begin
    st            = '0;
    st.bad        = req_bad;
    st.is_read    = (req_op == kvts_pkg::OP_READ);
    st.scan_last  = (scan_addr == LAST_IDX);
    st.hit        = hit;
    st.free_found = free_found;
    st.rsp_free   = !rsp_valid || rsp_ready;
  end

endmodule

/* rtl/key_value_table_store_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table store
// Fixed table of key/value records with write (update or insert) and read.
// ----------------------------------------------------------------------------
// Scan: the key scan reads one record per cycle through one port; a bad
//   argument skips the scan and goes straight to the result load.
// Flow: one request word at a time; the next is accepted only after the
//   result is loaded, which an output stall delays.
// Reset: synchronous; every slot reads free at once (per-slot occupied
//   bits), no clearing pass; values and lengths are not cleared.
`include "key_value_table_store_top_defines.svh"

module key_value_table_store_top #(
  parameter int RECORD_COUNT = kvts_pkg::RECORD_COUNT_DEF,
  parameter int KEY_BYTES    = kvts_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BYTES  = kvts_pkg::VALUE_BYTES_DEF
) (
  input logic       clk,
  input logic       rst,
  kvts_req_if.sink  req,
  kvts_rsp_if.source rsp
);

  kvts_pkg::kvts_cmd_t  cmd;
  kvts_pkg::kvts_stat_t st;
  logic                 req_ready;

  assign req.ready = req_ready;

  kvts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  kvts_datapath #(
    .RECORD_COUNT (RECORD_COUNT),
    .KEY_BYTES    (KEY_BYTES),
    .VALUE_BYTES  (VALUE_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .opcode       (req.opcode),
    .key_bytes    (req.key_bytes),
    .key_length   (req.key_length),
    .value_bytes  (req.value_bytes),
    .value_length (req.value_length),
    .cmd          (cmd),
    .st           (st),
    .rsp_ready    (rsp.ready),
    .rsp_valid    (rsp.valid),
    .rsp_status   (rsp.status),
    .rsp_value    (rsp.read_value),
    .rsp_length   (rsp.read_length)
  );

  `KVTS_ASSERT(a_busy_after_accept, clk, rst, (req.valid && req.ready) |=> !req.ready)
  `KVTS_ASSERT(a_load_only_when_free, clk, rst, cmd.load_rsp |-> (!rsp.valid || rsp.ready))
  `KVTS_ASSERT(a_write_has_slot, clk, rst, cmd.write |-> (st.hit || st.free_found))
  `KVTS_ASSERT_ALWAYS(a_rsp_idle_after_rst, clk, $past(rst) |-> !rsp.valid)

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table store testbench
// Drives write and read words into the table store and checks every result
// word against an in-bench model of the record table. Directed cases cover
// argument checks, unknown keys, insert, update, one long output hold that
// backs up the input channel and, after a random part with a key pool, idle
// gaps and output stalls on both sides, a full table.
// ----------------------------------------------------------------------------
module tb;

  localparam int RECORDS      = kvts_pkg::RECORD_COUNT_DEF;
  localparam int KEY_MAX      = kvts_pkg::KEY_BYTES_DEF;
  localparam int VAL_MAX      = kvts_pkg::VALUE_BYTES_DEF;
  localparam int RANDOM_WORDS = 700;
  localparam int POOL_SIZE    = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = RECORDS + 12;

  typedef logic [kvts_pkg::FIELD_W-1:0] word_t;
  typedef logic [kvts_pkg::LEN_W-1:0]   len_t;

  typedef struct {
    kvts_pkg::status_t status;
    word_t             value;
    len_t              length;
  } kv_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kvts_req_if req ();
  kvts_rsp_if rsp ();

  key_value_table_store_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the record table; a zero key means the slot is free
  word_t tbl_key   [RECORDS];
  word_t tbl_value [RECORDS];
  len_t  tbl_len   [RECORDS];

  kv_result_t expected_results[$];

  int  errors;
  int  words_sent;
  int  reads_sent;
  int  results_checked;
  int  status_seen [4];
  int  idle_cycles;
  bit  send_idle;
  bit  rsp_stall;
  bit  hold_rsp;

  function automatic word_t low_bytes(int n);
    if (n >= 8) return '1;
    return (word_t'(1) << (8 * n)) - word_t'(1);
  endfunction

  function automatic bit key_valid(word_t raw, len_t len, output word_t key);
    key = '0;
    if (len == 0 || len > KEY_MAX) return 1'b0;
    for (int i = 0; i < len; i++) begin
      if (raw[8*i +: 8] == 8'h00) return 1'b0;
    end
    key = raw & low_bytes(int'(len));
    return 1'b1;
  endfunction

  function automatic int find_slot(word_t key);
    for (int i = 0; i < RECORDS; i++) begin
      if (tbl_key[i] != '0 && tbl_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic int occupied();
    int n;
    n = 0;
    for (int i = 0; i < RECORDS; i++) begin
      if (tbl_key[i] != '0) n++;
    end
    return n;
  endfunction

  // result of one request; updates the table on a good write
  function automatic kv_result_t table_result(kvts_pkg::opcode_t op, word_t kraw,
                                              len_t klen, word_t vraw, len_t vlen);
    kv_result_t r;
    word_t      key;
    int         slot;
    r.status = kvts_pkg::ST_OK;
    r.value  = '0;
    r.length = '0;
    if (!key_valid(kraw, klen, key) ||
        (op == kvts_pkg::OP_WRITE && (vlen == 0 || vlen > VAL_MAX))) begin
      r.status = kvts_pkg::ST_BAD_ARG;
    end else begin
      slot = find_slot(key);
      if (op == kvts_pkg::OP_READ) begin
        if (slot < 0) begin
          r.status = kvts_pkg::ST_NOT_FOUND;
        end else begin
          r.value  = tbl_value[slot];
          r.length = tbl_len[slot];
        end
      end else begin
        // new key takes the lowest free slot
        for (int i = 0; i < RECORDS && slot < 0; i++) begin
          if (tbl_key[i] == '0) slot = i;
        end
        if (slot < 0) begin
          r.status = kvts_pkg::ST_FULL;
        end else begin
          tbl_key[slot]   = key;
          tbl_value[slot] = vraw & low_bytes(int'(vlen));
          tbl_len[slot]   = vlen;
        end
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t make_key(int len);
    word_t k;
    k = '0;
    for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // random bytes past the key length must not change the key
  function automatic word_t with_junk(word_t key, int len);
    return key | (rand_word() & ~low_bytes(len));
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  // valid stays high across back-to-back words; lowered only for a gap
  task automatic send_word(kvts_pkg::opcode_t op, word_t kraw, len_t klen, word_t vraw,
                           len_t vlen);
    int gap;
    gap = send_idle ? pick_gap() : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.opcode       <= op;
    req.key_bytes    <= kraw;
    req.key_length   <= klen;
    req.value_bytes  <= vraw;
    req.value_length <= vlen;
    do @(posedge clk); while (req.ready !== 1'b1);
    expected_results.push_back(table_result(op, kraw, klen, vraw, vlen));
    words_sent++;
    if (op == kvts_pkg::OP_READ) reads_sent++;
  endtask

  // result side ready, with random stalls and one requested long hold
  initial begin
    int n;
    rsp.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        hold_rsp = 1'b0;
        n = HOLD_CYCLES;
      end else if (rsp_stall && $urandom_range(0, 2) == 0) begin
        rsp.ready <= 1'b0;
        n = 1 + pick_gap();
      end else begin
        rsp.ready <= 1'b1;
        n = 1;
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    kv_result_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected, status %0d",
                                  rsp.status));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        status_seen[int'(want.status)]++;
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
        if (rsp.read_value !== want.value)
          report_mismatch($sformatf("read_value %h, expected %h",
                                    rsp.read_value, want.value));
        if (rsp.read_length !== want.length)
          report_mismatch($sformatf("read_length %0d, expected %0d",
                                    rsp.read_length, want.length));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_bad_arguments();
    send_word(kvts_pkg::OP_WRITE, 64'h41, 0, 64'h1, 1);
    send_word(kvts_pkg::OP_WRITE, '1, 9, 64'h1, 1);
    send_word(kvts_pkg::OP_READ, '1, 15, '0, 0);
    // zero byte inside the key
    send_word(kvts_pkg::OP_WRITE, 64'h43_0041, 3, 64'h55, 1);
    send_word(kvts_pkg::OP_READ, 64'h00FF_FFFF_FFFF_FFFF, 8, '0, 1);
    send_word(kvts_pkg::OP_WRITE, 64'h41, 1, '1, 0);
    send_word(kvts_pkg::OP_WRITE, 64'h41, 1, '1, 9);
    send_word(kvts_pkg::OP_WRITE, 64'h41, 1, '1, 15);
  endtask

  task automatic test_unknown_key();
    // value length is ignored on a read
    send_word(kvts_pkg::OP_READ, 64'h41, 1, '1, 15);
  endtask

  task automatic test_write_read();
    send_word(kvts_pkg::OP_WRITE, 64'hDEAD_BEEF_0000_0001, 1, 64'hFFFF_FFFF_FFFF_FF5A, 1);
    send_word(kvts_pkg::OP_WRITE, '1, 8, '1, 8);
    send_word(kvts_pkg::OP_WRITE, 64'h4241, 2, 64'h0123_4567_89AB_CDEF, 5);
    send_word(kvts_pkg::OP_WRITE, 64'h41, 1, 64'h77, 8);
    send_word(kvts_pkg::OP_READ, 64'hFFFF_FFFF_FFFF_FF01, 1, '0, 0);
    send_word(kvts_pkg::OP_READ, '1, 8, '0, 0);
    send_word(kvts_pkg::OP_READ, 64'h1200_0000_0000_4241, 2, '1, 15);
    // prefix of a longer key is its own record
    send_word(kvts_pkg::OP_READ, 64'h4241, 1, '0, 0);
  endtask

  task automatic test_update();
    send_word(kvts_pkg::OP_WRITE, 64'h4241, 2, '1, 3);
    send_word(kvts_pkg::OP_READ, 64'h4241, 2, '0, 0);
  endtask

  // output held off while words keep coming, so the input backs up
  task automatic test_back_pressure();
    send_idle = 1'b0;
    hold_rsp  = 1'b1;
    for (int i = 0; i < 6; i++) begin
      if (i % 2 == 0) send_word(kvts_pkg::OP_READ, '1, 8, '0, 0);
      else send_word(kvts_pkg::OP_WRITE, make_key(3), 3, rand_word(),
                     len_t'($urandom_range(1, VAL_MAX)));
    end
    send_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    word_t             pool_key [POOL_SIZE];
    int                pool_len [POOL_SIZE];
    word_t             k;
    int                len;
    int                p;
    int                r;
    int                z;
    kvts_pkg::opcode_t op;
    len_t              vlen;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_len[i] = $urandom_range(1, KEY_MAX);
      pool_key[i] = make_key(pool_len[i]);
    end
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // every 100 words change idling: none, one side, both sides
      send_idle = (((i / 100) % 4) & 1) != 0;
      rsp_stall = ((i / 100) % 4) >= 2;
      r  = $urandom_range(0, 99);
      op = kvts_pkg::opcode_t'($urandom_range(0, 1));
      if (r < 80) begin
        p = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 9) != 0) vlen = len_t'($urandom_range(1, VAL_MAX));
        else vlen = len_t'($urandom_range(0, 1) ? 0 : $urandom_range(VAL_MAX + 1, 15));
        send_word(op, with_junk(pool_key[p], pool_len[p]), len_t'(pool_len[p]),
                  rand_word(), vlen);
      end else if (r < 90) begin
        case ($urandom_range(0, 2))
          0: send_word(op, rand_word(), 0, rand_word(),
                       len_t'($urandom_range(1, VAL_MAX)));
          1: send_word(op, rand_word(), len_t'($urandom_range(KEY_MAX + 1, 15)),
                       rand_word(), len_t'($urandom_range(1, VAL_MAX)));
          default: begin
            len = $urandom_range(2, KEY_MAX);
            k   = make_key(len);
            z   = $urandom_range(0, len - 1);
            k[8*z +: 8] = 8'h00;
            send_word(op, with_junk(k, len), len_t'(len), rand_word(),
                      len_t'($urandom_range(1, VAL_MAX)));
          end
        endcase
      end else begin
        send_word(op, rand_word(), len_t'($urandom_range(0, 15)), rand_word(),
                  len_t'($urandom_range(0, 15)));
      end
    end
    send_idle = 1'b1;
    rsp_stall = 1'b1;
  endtask

  task automatic test_full_table();
    word_t k;
    int    len;
    while (occupied() < RECORDS) begin
      len = $urandom_range(1, KEY_MAX);
      k   = make_key(len);
      if (find_slot(k) < 0)
        send_word(kvts_pkg::OP_WRITE, k, len_t'(len), rand_word(),
                  len_t'($urandom_range(1, VAL_MAX)));
    end
    do begin
      len = $urandom_range(1, KEY_MAX);
      k   = make_key(len);
    end while (find_slot(k) >= 0);
    send_word(kvts_pkg::OP_WRITE, with_junk(k, len), len_t'(len), rand_word(),
              len_t'($urandom_range(1, VAL_MAX)));
    send_word(kvts_pkg::OP_READ, k, len_t'(len), '0, 0);
    // update still works with no free slot
    send_word(kvts_pkg::OP_WRITE, '1, 8, rand_word(), 8);
    send_word(kvts_pkg::OP_READ, '1, 8, '0, 0);
  endtask

  initial begin
    req.valid        = 1'b0;
    req.opcode       = 1'b0;
    req.key_bytes    = '0;
    req.key_length   = '0;
    req.value_bytes  = '0;
    req.value_length = '0;
    for (int i = 0; i < RECORDS; i++) tbl_key[i] = '0;
    send_idle = 1'b1;
    rsp_stall = 1'b1;
    hold_rsp  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_bad_arguments();
    test_unknown_key();
    test_write_read();
    test_update();
    test_back_pressure();
    test_random_traffic();
    test_full_table();
    req.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("sent %0d request words (%0d reads), checked %0d result words",
             words_sent, reads_sent, results_checked);
    $display("results by status: ok %0d, bad argument %0d, table full %0d, not found %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
